>>> hw/rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed: label");

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed: label");

`endif

>>> hw/rtl/vnf_pkg.sv
// types, constants and hash helper for the value noise tile classifier
// no dependencies
`timescale 1ns / 1ps

package vnf_pkg;

  localparam int GRID_TILES = 128;
  localparam int COORD_W = 7;
  localparam int SCALE_NUM = 6 * 65536;
  localparam int OCTAVES = 4;
  localparam int P0_W = $clog2(((1 << COORD_W) - 1) * SCALE_NUM / GRID_TILES + 1);
  localparam int P_W = P0_W + OCTAVES - 1;
  localparam int CELL_W = P_W - 16 + 1;
  localparam int HALF = GRID_TILES / 2;
  localparam int DX_W = (COORD_W > $clog2(GRID_TILES)) ? COORD_W + 1 : $clog2(GRID_TILES) + 1;
  localparam int DIST_W = 2 * DX_W;

  localparam logic [31:0] HASH_X = 32'd1619;
  localparam logic [31:0] HASH_Y = 32'd31337;
  localparam logic [31:0] HASH_SEED = 32'd6271;
  localparam logic [31:0] HASH_MIX = 32'h045d9f3b;
  localparam logic [17:0] SMOOTH_THREE = 18'd196608;

  localparam logic [31:0] RST_SEED = 32'd0;
  localparam logic [15:0] RST_RUIN = 16'd47186;
  localparam logic [15:0] RST_HARDPAN = 16'd38011;
  localparam logic [15:0] RST_SAND = 16'd22938;
  localparam logic [9:0] RST_SPAWN = 10'd25;

  typedef enum logic [2:0] {
    REG_SEED,
    REG_RUIN,
    REG_HARDPAN,
    REG_SAND,
    REG_SPAWN
  } reg_idx_t;

  typedef enum logic [1:0] {
    CLS_DUNE,
    CLS_SAND,
    CLS_HARDPAN,
    CLS_RUIN
  } class_t;

  typedef struct packed {
    logic [COORD_W-1:0] tile_x;
    logic [COORD_W-1:0] tile_y;
  } tile_in_t;

  typedef struct packed {
    logic [1:0] tile_class;
    logic [15:0] noise_value;
  } tile_out_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

  function automatic logic [31:0] hash_pre(input logic [CELL_W-1:0] cx,
                                           input logic [CELL_W-1:0] cy,
                                           input logic [31:0] seed);
    logic [31:0] h;
    h = 32'(cx) * HASH_X + 32'(cy) * HASH_Y + seed * HASH_SEED;
    return h ^ (h >> 16);
  endfunction

endpackage

>>> hw/rtl/vnf_octave.sv
// one noise octave: lattice hashes, smoothstep weights, bilinear blend
// five register stages; depends on vnf_pkg
`timescale 1ns / 1ps

module vnf_octave (
  input  logic                      clk,
  input  vnf_pkg::stage_en_t        en,
  input  logic [vnf_pkg::P_W-1:0]   px,
  input  logic [vnf_pkg::P_W-1:0]   py,
  input  logic [31:0]               noise_seed,
  output logic [15:0]               oct_value
);

  localparam int CW = vnf_pkg::CELL_W;

  logic [CW-1:0] ix, iy, ix1, iy1;
  logic [31:0] h1_c [4];
  logic [31:0] fxx, fyy;

  logic [31:0] h1 [4];
  logic [15:0] f2x, f2y, fx1, fy1;

  logic [33:0] sx_prod, sy_prod;
  logic [31:0] h2 [4];
  logic [16:0] sx2, sy2;

  logic [15:0] cv [4];
  logic signed [17:0] ba, ca, e, sxs;
  logic [15:0] a3;
  logic signed [17:0] ca3;
  logic [16:0] sy3;
  logic signed [35:0] m1_3, m2_3;

  logic signed [36:0] t;
  logic [15:0] a4;
  logic signed [35:0] m1_4;
  logic [34:0] plo4;
  logic signed [36:0] phi4;

  logic signed [55:0] acc;

  assign ix = CW'(px[vnf_pkg::P_W-1:16]);
  assign iy = CW'(py[vnf_pkg::P_W-1:16]);
  assign ix1 = ix + CW'(1);
  assign iy1 = iy + CW'(1);
  assign h1_c[0] = vnf_pkg::hash_pre(ix, iy, noise_seed);
  assign h1_c[1] = vnf_pkg::hash_pre(ix1, iy, noise_seed);
  assign h1_c[2] = vnf_pkg::hash_pre(ix, iy1, noise_seed);
  assign h1_c[3] = vnf_pkg::hash_pre(ix1, iy1, noise_seed);
  assign fxx = px[15:0] * px[15:0];
  assign fyy = py[15:0] * py[15:0];

  always_ff @(posedge clk) begin
    if (en.s1) begin
      for (int i = 0; i < 4; i++) h1[i] <= h1_c[i];
      f2x <= fxx[31:16];
      f2y <= fyy[31:16];
      fx1 <= px[15:0];
      fy1 <= py[15:0];
    end
  end

  assign sx_prod = f2x * (vnf_pkg::SMOOTH_THREE - {1'b0, fx1, 1'b0});
  assign sy_prod = f2y * (vnf_pkg::SMOOTH_THREE - {1'b0, fy1, 1'b0});

  always_ff @(posedge clk) begin
    if (en.s2) begin
      for (int i = 0; i < 4; i++) h2[i] <= h1[i] * vnf_pkg::HASH_MIX;
      sx2 <= sx_prod[32:16];
      sy2 <= sy_prod[32:16];
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) cv[i] = h2[i][15:0] ^ h2[i][31:16];
  end
  assign ba = $signed({2'b00, cv[1]}) - $signed({2'b00, cv[0]});
  assign ca = $signed({2'b00, cv[2]}) - $signed({2'b00, cv[0]});
  assign e = $signed({2'b00, cv[0]}) - $signed({2'b00, cv[1]})
           - $signed({2'b00, cv[2]}) + $signed({2'b00, cv[3]});
  assign sxs = $signed({1'b0, sx2});

  always_ff @(posedge clk) begin
    if (en.s3) begin
      a3 <= cv[0];
      ca3 <= ca;
      sy3 <= sy2;
      m1_3 <= ba * sxs;
      m2_3 <= e * sxs;
    end
  end

  assign t = (37'(ca3) <<< 16) + 37'(m2_3);

  always_ff @(posedge clk) begin
    if (en.s4) begin
      a4 <= a3;
      m1_4 <= m1_3;
      plo4 <= sy3 * t[17:0];
      phi4 <= $signed({1'b0, sy3}) * $signed(t[36:18]);
    end
  end

  assign acc = (56'($signed({1'b0, a4})) <<< 32) + (56'(m1_4) <<< 16)
             + 56'($signed({1'b0, plo4})) + (56'(phi4) <<< 18);

  always_ff @(posedge clk) begin
    if (en.s5) begin
      oct_value <= acc[55] ? 16'd0 : acc[47:32];
    end
  end

endmodule

>>> hw/rtl/value_noise_fbm_tile_classifier.sv
// an accepted beat passes stages s1 to s5 and then the output register to out_valid
// one beat per cycle when not stalled; a stage holds only while its successor is full
// four octave lanes run side by side, each a five stage hash and blend pipeline
// reset: rst synchronous, active high, clears all stage valids and loads register defaults
// depends on vnf_pkg and vnf_octave
`timescale 1ns / 1ps

module value_noise_fbm_tile_classifier (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  vnf_pkg::tile_in_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output vnf_pkg::tile_out_t out_data,
  input  logic               cfg_wen,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int OCT = vnf_pkg::OCTAVES;
  localparam int DW = vnf_pkg::DIST_W;
  localparam int XW = vnf_pkg::DX_W;

  logic [31:0] noise_seed;
  logic [15:0] ruin_threshold, hardpan_threshold, sand_threshold;
  logic [9:0] spawn_radius_squared;

  logic [5:1] v;
  vnf_pkg::stage_en_t en;
  logic en6;

  logic [vnf_pkg::P0_W-1:0] px0, py0;
  logic [vnf_pkg::P_W-1:0] pxk [OCT], pyk [OCT];
  logic [15:0] oct [OCT];

  logic signed [XW-1:0] dx, dy;
  logic [DW-1:0] dist_c;
  logic [DW-1:0] dist_pipe [5:1];

  logic [15:0] sum;
  vnf_pkg::class_t cls;

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_seed <= vnf_pkg::RST_SEED;
      ruin_threshold <= vnf_pkg::RST_RUIN;
      hardpan_threshold <= vnf_pkg::RST_HARDPAN;
      sand_threshold <= vnf_pkg::RST_SAND;
      spawn_radius_squared <= vnf_pkg::RST_SPAWN;
    end else if (cfg_wen) begin
      case (cfg_index)
        vnf_pkg::REG_SEED:    noise_seed <= cfg_data;
        vnf_pkg::REG_RUIN:    ruin_threshold <= cfg_data[15:0];
        vnf_pkg::REG_HARDPAN: hardpan_threshold <= cfg_data[15:0];
        vnf_pkg::REG_SAND:    sand_threshold <= cfg_data[15:0];
        vnf_pkg::REG_SPAWN:   spawn_radius_squared <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // stage enables: a stage moves when empty or when its successor moves
  assign en6 = !out_valid || out_ready;
  assign en.s5 = !v[5] || en6;
  assign en.s4 = !v[4] || en.s5;
  assign en.s3 = !v[3] || en.s4;
  assign en.s2 = !v[2] || en.s3;
  assign en.s1 = !v[1] || en.s2;
  assign in_ready = en.s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      out_valid <= 1'b0;
    end else begin
      if (en.s1) v[1] <= in_valid;
      if (en.s2) v[2] <= v[1];
      if (en.s3) v[3] <= v[2];
      if (en.s4) v[4] <= v[3];
      if (en.s5) v[5] <= v[4];
      if (en6) out_valid <= v[5];
    end
  end

  assign px0 = vnf_pkg::P0_W'((32'(in_data.tile_x) * 32'(vnf_pkg::SCALE_NUM))
                              / vnf_pkg::GRID_TILES);
  assign py0 = vnf_pkg::P0_W'((32'(in_data.tile_y) * 32'(vnf_pkg::SCALE_NUM))
                              / vnf_pkg::GRID_TILES);

  for (genvar k = 0; k < OCT; k++) begin : g_oct
    assign pxk[k] = vnf_pkg::P_W'(px0) << k;
    assign pyk[k] = vnf_pkg::P_W'(py0) << k;
    vnf_octave u_oct (
      .clk        (clk),
      .en         (en),
      .px         (pxk[k]),
      .py         (pyk[k]),
      .noise_seed (noise_seed),
      .oct_value  (oct[k])
    );
  end

  assign dx = $signed(XW'(in_data.tile_x)) - $signed(XW'(vnf_pkg::HALF));
  assign dy = $signed(XW'(in_data.tile_y)) - $signed(XW'(vnf_pkg::HALF));
  assign dist_c = DW'(dx) * DW'(dx) + DW'(dy) * DW'(dy);

  always_ff @(posedge clk) begin
    if (en.s1) dist_pipe[1] <= dist_c;
    if (en.s2) dist_pipe[2] <= dist_pipe[1];
    if (en.s3) dist_pipe[3] <= dist_pipe[2];
    if (en.s4) dist_pipe[4] <= dist_pipe[3];
    if (en.s5) dist_pipe[5] <= dist_pipe[4];
  end

  always_comb begin
    sum = '0;
    for (int k = 0; k < OCT; k++) sum = sum + (oct[k] >> (k + 1));
    if (sum > ruin_threshold) cls = vnf_pkg::CLS_RUIN;
    else if (sum > hardpan_threshold) cls = vnf_pkg::CLS_HARDPAN;
    else if (sum > sand_threshold) cls = vnf_pkg::CLS_SAND;
    else cls = vnf_pkg::CLS_DUNE;
    // spawn disc overrides the noise class
    if (dist_pipe[5] < DW'(spawn_radius_squared)) cls = vnf_pkg::CLS_HARDPAN;
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      out_data.tile_class <= 2'(cls);
      out_data.noise_value <= sum;
    end
  end

endmodule

>>> hw/rtl/vnf_checker.sv
// port level checks for the tile classifier, bound to the top level
// depends on vnf_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vnf_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input vnf_pkg::tile_in_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input vnf_pkg::tile_out_t out_data
);

  `ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid)
  `ASSERT_CLK(a_ready_when_drained, (!out_valid || out_ready) |-> in_ready)
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid)
  `ASSERT_CLK(a_out_stable, out_valid && !out_ready |=> $stable(out_data))
  `ASSERT_CLK(a_in_hold, in_valid && !in_ready |=> in_valid && $stable(in_data))

endmodule

bind value_noise_fbm_tile_classifier vnf_checker u_vnf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
